// File: rtl/core/psq_pkg.sv
package psq_pkg;

    localparam int NUM_POS = 5;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_marker;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       bad_code;
        logic       last_of_run;
    } result_t;

    typedef logic [NUM_POS-1:0][2:0] label_set_t;

    typedef enum logic [2:0] {
        CFG_DIRECTION = 3'd0,
        CFG_LABEL_0   = 3'd1,
        CFG_LABEL_1   = 3'd2,
        CFG_LABEL_2   = 3'd3,
        CFG_LABEL_3   = 3'd4,
        CFG_LABEL_4   = 3'd5
    } cfg_index_t;

    typedef enum logic {
        DIR_ENCIPHER = 1'b0,
        DIR_DECIPHER = 1'b1
    } direction_t;

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CHAR_UPPER_I = 8'd73;
    localparam logic [7:0] CHAR_UPPER_J = 8'd74;
    localparam logic [7:0] CHAR_LOWER_I = 8'd105;
    localparam logic [7:0] CHAR_LOWER_J = 8'd106;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [4:0] SKIPPED_POS  = 5'd9;

    // square row of a position 0..24
    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)
        begin
            r = 3'd4;
        end
        else if (p >= 5'd15)
        begin
            r = 3'd3;
        end
        else if (p >= 5'd10)
        begin
            r = 3'd2;
        end
        else if (p >= 5'd5)
        begin
            r = 3'd1;
        end
        else
        begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] p, input logic [2:0] r);
        logic [4:0] c;
        c = p - {r, 2'b00} - {2'b00, r};
        return c[2:0];
    endfunction

    // lowest position carrying digit d; msb is the found flag
    function automatic logic [3:0] find_pos(input logic [3:0] d, input label_set_t lab);
        logic [3:0] res;
        res = '0;
        if (d >= 4'd1 && d <= 4'd5)
        begin
            for (int k = NUM_POS - 1; k >= 0; k--)
            begin
                if (lab[k] == d[2:0])
                begin
                    res = {1'b1, 3'(k)};
                end
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/polybius_square_codec.sv
// Polybius square codec, 5x5 square without J, one ASCII byte per transaction.
// item channel: item_valid / item_stall with an item_t payload (in_char, end_marker).
// result channel: result_valid / result_stall with a result_t payload.
// configuration: cfg_valid / cfg_ready write port, cfg_index 0 is the direction,
// 1..5 are the row and column labels; cfg_ready is always high and the user
// must make writes only while the block is idle, which the block does not enforce.
// an accepted item is held in the input register, then all of its work is
// done in one pass into a two-entry result register, from which its first result
// is offered; the move waits while that register cannot take the item's results.
// items giving zero or one result are taken every cycle while the receiver does
// not stall; an enciphered letter gives two results, so letters are limited by the
// single result output: the next item moves on only as the second result is taken.
// while the receiver stalls, results hold and the input register fills, after
// which item_stall rises.
// reset clears the direction to encipher, the labels to 1..5, the held digit and
// all valid state.
module polybius_square_codec
    import psq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [2:0] cfg_data
);

    logic        inp_valid_reg;
    item_t       inp_reg;
    result_t     res0_reg;
    result_t     res1_reg;
    logic [1:0]  res_cnt_reg;
    logic [1:0]  res_cnt_next;
    result_t     res0_next;
    result_t     res1_next;
    direction_t  direction_reg;
    label_set_t  label_reg;
    logic        digit_pending_reg;
    logic [3:0]  held_digit_reg;

    logic        pop;
    logic        move;
    logic        item_take;
    logic [1:0]  n_res;
    result_t     r0;
    result_t     r1;
    logic        pend_next;
    logic [3:0]  held_next;

    logic [7:0]  ch;
    logic        is_upper;
    logic        is_lower;
    logic        is_digit;
    logic [4:0]  idx;
    logic [4:0]  sq_pos;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [3:0]  find_r;
    logic [3:0]  find_c;
    logic [4:0]  pair_pos;
    logic [7:0]  letter;

    assign cfg_ready    = 1'b1;
    assign result_valid = (res_cnt_reg != 2'd0);
    assign result       = res0_reg;
    assign pop          = result_valid && !result_stall;
    assign move         = inp_valid_reg && ((res_cnt_reg == 2'd0) ||
                          (res_cnt_reg == 2'd1 && pop));
    assign item_stall   = inp_valid_reg && !move;
    assign item_take    = item_valid && !item_stall;

    // decode
    always_comb
    begin
        ch = inp_reg.in_char;
        if (ch == CHAR_UPPER_J)
        begin
            ch = CHAR_UPPER_I;
        end
        else if (ch == CHAR_LOWER_J)
        begin
            ch = CHAR_LOWER_I;
        end
        is_upper = (ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z);
        is_lower = (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z);
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        idx      = is_upper ? 5'(ch - CHAR_UPPER_A) : 5'(ch - CHAR_LOWER_A);
        sq_pos   = (idx > SKIPPED_POS) ? idx - 5'd1 : idx;
        row      = pos_row(sq_pos);
        col      = pos_col(sq_pos, row);
        find_r   = find_pos(held_digit_reg, label_reg);
        find_c   = find_pos(ch[3:0], label_reg);
        pair_pos = {find_r[2:0], 2'b00} + {2'b00, find_r[2:0]} + {2'b00, find_c[2:0]};
        letter   = CHAR_UPPER_A + {3'b000, pair_pos}
                   + {7'd0, (pair_pos >= SKIPPED_POS)};
    end

    // one pass over the held item
    always_comb
    begin
        n_res     = 2'd0;
        r0        = '0;
        r1        = '0;
        pend_next = digit_pending_reg;
        held_next = held_digit_reg;
        if (inp_reg.end_marker)
        begin
            pend_next = 1'b0;
            held_next = '0;
            if (digit_pending_reg)
            begin
                n_res = 2'd1;
                r0    = '{out_char: 8'd0, bad_code: 1'b1, last_of_run: 1'b1};
            end
        end
        else if (direction_reg == DIR_ENCIPHER)
        begin
            if (is_upper || is_lower)
            begin
                n_res = 2'd2;
                r0    = '{out_char: CHAR_ZERO + {5'd0, label_reg[row]},
                          bad_code: 1'b0, last_of_run: 1'b0};
                r1    = '{out_char: CHAR_ZERO + {5'd0, label_reg[col]},
                          bad_code: 1'b0, last_of_run: 1'b1};
            end
            else
            begin
                n_res = 2'd1;
                r0    = '{out_char: ch, bad_code: 1'b0, last_of_run: 1'b1};
            end
        end
        else if (!digit_pending_reg)
        begin
            if (is_digit)
            begin
                pend_next = 1'b1;
                held_next = ch[3:0];
            end
            else
            begin
                n_res = 2'd1;
                r0    = '{out_char: ch, bad_code: 1'b0, last_of_run: 1'b1};
            end
        end
        else
        begin
            pend_next = 1'b0;
            held_next = '0;
            n_res     = 2'd1;
            if (is_digit && find_r[3] && find_c[3])
            begin
                r0 = '{out_char: letter, bad_code: 1'b0, last_of_run: 1'b1};
            end
            else
            begin
                r0 = '{out_char: 8'd0, bad_code: 1'b1, last_of_run: 1'b1};
            end
        end
    end

    // result buffer
    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        if (move)
        begin
            res_cnt_next = n_res;
            res0_next    = r0;
            res1_next    = r1;
        end
        else if (pop)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
            res0_next    = res1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inp_valid_reg     <= 1'b0;
            res_cnt_reg       <= 2'd0;
            direction_reg     <= DIR_ENCIPHER;
            digit_pending_reg <= 1'b0;
            held_digit_reg    <= '0;
            for (int k = 0; k < NUM_POS; k++)
            begin
                label_reg[k] <= 3'(k + 1);
            end
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (item_take)
            begin
                inp_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                inp_valid_reg <= 1'b0;
            end
            if (move)
            begin
                digit_pending_reg <= pend_next;
                held_digit_reg    <= held_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DIRECTION:
                    begin
                        direction_reg     <= direction_t'(cfg_data[0]);
                        digit_pending_reg <= 1'b0;
                        held_digit_reg    <= '0;
                    end
                    CFG_LABEL_0: label_reg[0] <= cfg_data;
                    CFG_LABEL_1: label_reg[1] <= cfg_data;
                    CFG_LABEL_2: label_reg[2] <= cfg_data;
                    CFG_LABEL_3: label_reg[3] <= cfg_data;
                    CFG_LABEL_4: label_reg[4] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            inp_reg <= item;
        end
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg != 2'd3)
        else $error("result count out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        move && n_res == 2'd2 |=> !res0_reg.last_of_run && res1_reg.last_of_run)
        else $error("digit pair loaded with wrong last marks");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_code |-> result.out_char == 8'd0)
        else $error("bad result carries a character");

    a_no_pending_enc: assert property (@(posedge clk) disable iff (!rst_n)
        direction_reg == DIR_ENCIPHER |-> !digit_pending_reg)
        else $error("digit held while enciphering");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> inp_valid_reg && result_valid)
        else $error("stall without a held transaction");
`endif

endmodule

// File: dv/tb.sv
module tb;
    import psq_pkg::*;

    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 80;
    localparam int NUM_PHASES      = 14;
    localparam int ITEMS_PER_PHASE = 100;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

    typedef struct {
        row_kind_t  kind;
        cfg_index_t idx;
        logic [2:0] data;
        item_t      it;
        int         n_typed;
        result_t    t0;
        result_t    t1;
    } step_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    item_t      item;
    logic       result_valid;
    logic       result_stall;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [2:0] cfg_data;

    // square model state
    direction_t sq_dir;
    label_set_t sq_label;
    bit         sq_pending;
    logic [3:0] sq_held;

    result_t expected_codes[$];
    step_t   directed_steps[$];

    int  errors;
    int  items_sent;
    int  results_checked;
    int  long_holds;
    int  burst_left;
    int  gap_max;
    bit  hold_req;

    polybius_square_codec dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t code_out(input logic [7:0] c, input logic b, input logic l);
        result_t r;
        r.out_char    = c;
        r.bad_code    = b;
        r.last_of_run = l;
        return r;
    endfunction

    function automatic item_t byte_item(input logic [7:0] c, input logic e);
        item_t it;
        it.in_char    = c;
        it.end_marker = e;
        return it;
    endfunction

    // lowest square slot carrying digit d, -1 when none
    function automatic int label_slot(input logic [3:0] d);
        int slot;
        slot = -1;
        if (d >= 4'd1 && d <= 4'd5)
        begin
            for (int k = NUM_POS - 1; k >= 0; k--)
            begin
                if (sq_label[k] == d[2:0])
                begin
                    slot = k;
                end
            end
        end
        return slot;
    endfunction

    function automatic void predict_codes(input item_t it, output result_t r0,
                                          output result_t r1, output int n);
        logic [7:0] ch;
        logic [3:0] first;
        int         letter;
        int         sq_slot;
        int         row_slot;
        int         col_slot;
        bit         is_digit;
        r0 = '0;
        r1 = '0;
        n  = 0;
        ch = it.in_char;
        if (it.end_marker)
        begin
            if (sq_pending)
            begin
                sq_pending = 1'b0;
                sq_held    = '0;
                r0         = code_out(8'h00, 1'b1, 1'b1);
                n          = 1;
            end
            return;
        end
        if (ch == CHAR_UPPER_J)
        begin
            ch = CHAR_UPPER_I;
        end
        else if (ch == CHAR_LOWER_J)
        begin
            ch = CHAR_LOWER_I;
        end
        if (sq_dir == DIR_ENCIPHER)
        begin
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
            begin
                letter = int'(ch) - int'(CHAR_UPPER_A);
            end
            else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
            begin
                letter = int'(ch) - int'(CHAR_LOWER_A);
            end
            else
            begin
                r0 = code_out(ch, 1'b0, 1'b1);
                n  = 1;
                return;
            end
            sq_slot = (letter > int'(SKIPPED_POS)) ? letter - 1 : letter;
            r0      = code_out(CHAR_ZERO + 8'(sq_label[sq_slot / 5]), 1'b0, 1'b0);
            r1      = code_out(CHAR_ZERO + 8'(sq_label[sq_slot % 5]), 1'b0, 1'b1);
            n       = 2;
            return;
        end
        is_digit = (ch >= CHAR_ZERO && ch <= CHAR_NINE);
        if (!sq_pending)
        begin
            if (is_digit)
            begin
                sq_pending = 1'b1;
                sq_held    = 4'(ch - CHAR_ZERO);
            end
            else
            begin
                r0 = code_out(ch, 1'b0, 1'b1);
                n  = 1;
            end
            return;
        end
        first      = sq_held;
        sq_pending = 1'b0;
        sq_held    = '0;
        n          = 1;
        row_slot   = label_slot(first);
        col_slot   = is_digit ? label_slot(4'(ch - CHAR_ZERO)) : -1;
        if (!is_digit || row_slot < 0 || col_slot < 0)
        begin
            r0 = code_out(8'h00, 1'b1, 1'b1);
        end
        else
        begin
            sq_slot = row_slot * 5 + col_slot;
            r0      = code_out(8'(int'(CHAR_UPPER_A) + sq_slot +
                                  (sq_slot >= int'(SKIPPED_POS) ? 1 : 0)),
                               1'b0, 1'b1);
        end
    endfunction

    function automatic void add_cfg(input cfg_index_t idx, input logic [2:0] data);
        step_t s;
        s.kind    = ROW_CFG;
        s.idx     = idx;
        s.data    = data;
        s.it      = '0;
        s.n_typed = -1;
        s.t0      = '0;
        s.t1      = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_checked(input logic [7:0] c, input logic e, input int n,
                                        input result_t t0, input result_t t1);
        step_t s;
        s.kind    = ROW_ITEM;
        s.idx     = CFG_DIRECTION;
        s.data    = '0;
        s.it      = byte_item(c, e);
        s.n_typed = n;
        s.t0      = t0;
        s.t1      = t1;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_char(input logic [7:0] c, input logic e);
        add_checked(c, e, -1, '0, '0);
    endfunction

    task automatic offer_item(input item_t it, input int n_typed,
                              input result_t t0, input result_t t1);
        result_t p0;
        result_t p1;
        int      np;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        predict_codes(it, p0, p1, np);
        if (n_typed >= 0)
        begin
            np = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (np > 0)
        begin
            expected_codes.push_back(p0);
        end
        if (np > 1)
        begin
            expected_codes.push_back(p1);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (expected_codes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [2:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_DIRECTION)
        begin
            sq_dir     = direction_t'(data[0]);
            sq_pending = 1'b0;
            sq_held    = '0;
        end
        else
        begin
            sq_label[int'(idx) - int'(CFG_LABEL_0)] = data;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_codes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, got char %h bad %b last %b",
                         $time, result.out_char, result.bad_code, result.last_of_run);
            end
            else
            begin
                want = expected_codes.pop_front();
                results_checked++;
                if (result.out_char !== want.out_char || result.bad_code !== want.bad_code ||
                    result.last_of_run !== want.last_of_run)
                begin
                    errors++;
                    $display("%0t: mismatch, expected char %h bad %b last %b, got char %h bad %b last %b",
                             $time, want.out_char, want.bad_code, want.last_of_run,
                             result.out_char, result.bad_code, result.last_of_run);
                end
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        flow_mode_t mode;
        int         span;
        mode         = FLOW_FREE;
        span         = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                long_holds++;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = flow_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 120);
                end
                span--;
                case (mode)
                    FLOW_FREE:  result_stall <= 1'b0;
                    FLOW_LIGHT: result_stall <= ($urandom_range(0, 99) < 30);
                    FLOW_HEAVY: result_stall <= ($urandom_range(0, 99) < 75);
                    default:    result_stall <= (span % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        #5000000;
        $display("%0t: run did not finish in time", $time);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        item_t      it;
        item_t      run_q[$];
        logic [2:0] lab[NUM_POS];
        logic [2:0] tmp;
        int         phase;
        int         count;
        int         pick;
        int         style;
        int         j;
        logic [7:0] d0;
        bit         hold_armed;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_DIRECTION;
        cfg_data   = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        gap_max    = 3;
        errors     = 0;
        sq_dir     = DIR_ENCIPHER;
        sq_label   = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
        sq_pending = 1'b0;
        sq_held    = '0;

        // encipher with reset labels
        add_checked("A", 1'b0, 2, code_out("1", 1'b0, 1'b0), code_out("1", 1'b0, 1'b1));
        add_checked("Z", 1'b0, 2, code_out("5", 1'b0, 1'b0), code_out("5", 1'b0, 1'b1));
        add_checked("j", 1'b0, 2, code_out("2", 1'b0, 1'b0), code_out("4", 1'b0, 1'b1));
        add_checked(8'hff, 1'b0, 1, code_out(8'hff, 1'b0, 1'b1), '0);
        add_checked(8'h00, 1'b0, 1, code_out(8'h00, 1'b0, 1'b1), '0);
        add_checked("A", 1'b1, 0, '0, '0);
        // labels outside 1..5
        add_cfg(CFG_LABEL_0, 3'd0);
        add_cfg(CFG_LABEL_4, 3'd7);
        add_checked("a", 1'b0, 2, code_out("0", 1'b0, 1'b0), code_out("0", 1'b0, 1'b1));
        add_checked("z", 1'b0, 2, code_out("7", 1'b0, 1'b0), code_out("7", 1'b0, 1'b1));
        // decipher
        add_cfg(CFG_LABEL_0, 3'd1);
        add_cfg(CFG_LABEL_4, 3'd5);
        add_cfg(CFG_DIRECTION, 3'(DIR_DECIPHER));
        add_checked("1", 1'b0, 0, '0, '0);
        add_checked("1", 1'b0, 1, code_out("A", 1'b0, 1'b1), '0);
        add_checked("5", 1'b0, 0, '0, '0);
        add_checked("5", 1'b0, 1, code_out("Z", 1'b0, 1'b1), '0);
        add_checked("0", 1'b0, 0, '0, '0);
        add_checked("1", 1'b0, 1, code_out(8'h00, 1'b1, 1'b1), '0);
        add_checked("9", 1'b0, 0, '0, '0);
        add_checked("x", 1'b0, 1, code_out(8'h00, 1'b1, 1'b1), '0);
        add_checked("J", 1'b0, 1, code_out("I", 1'b0, 1'b1), '0);
        add_checked("4", 1'b0, 0, '0, '0);
        add_checked(8'h00, 1'b1, 1, code_out(8'h00, 1'b1, 1'b1), '0);
        add_checked(8'h80, 1'b0, 1, code_out(8'h80, 1'b0, 1'b1), '0);
        // duplicate and missing labels, pending digit dropped by a direction write
        add_cfg(CFG_LABEL_1, 3'd1);
        add_cfg(CFG_LABEL_2, 3'd7);
        add_char("3", 1'b0);
        add_cfg(CFG_DIRECTION, 3'(DIR_DECIPHER));
        add_char("1", 1'b0);
        add_char("4", 1'b0);
        // label change while a digit is held
        add_char("1", 1'b0);
        add_cfg(CFG_LABEL_0, 3'd4);
        add_char("1", 1'b0);
        add_char("4", 1'b0);
        add_char("4", 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            end
            else
            begin
                offer_item(directed_steps[i].it, directed_steps[i].n_typed,
                           directed_steps[i].t0, directed_steps[i].t1);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            style = $urandom_range(0, 3);
            for (int k = 0; k < NUM_POS; k++)
            begin
                lab[k] = 3'(k + 1);
            end
            for (int k = NUM_POS - 1; k > 0; k--)
            begin
                j      = $urandom_range(0, k);
                tmp    = lab[k];
                lab[k] = lab[j];
                lab[j] = tmp;
            end
            for (int k = 0; k < NUM_POS; k++)
            begin
                if (style == 2)
                begin
                    lab[k] = 3'($urandom_range(0, 7));
                end
                else if (style == 3)
                begin
                    case ($urandom_range(0, 3))
                        0:       lab[k] = 3'd0;
                        1:       lab[k] = 3'd7;
                        2:       lab[k] = 3'd1;
                        default: lab[k] = 3'd5;
                    endcase
                end
            end
            if (phase == 0 || $urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_DIRECTION, 3'($urandom_range(0, 1)));
            end
            for (int k = 0; k < NUM_POS; k++)
            begin
                write_reg(cfg_index_t'(int'(CFG_LABEL_0) + k), lab[k]);
            end
            gap_max    = (phase % 4 == 1) ? 0 : $urandom_range(1, 8);
            hold_armed = (phase == 3 || phase == 10);
            count      = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                if (hold_armed && count >= 10)
                begin
                    hold_req   = 1'b1;
                    hold_armed = 1'b0;
                end
                run_q.delete();
                pick = $urandom_range(0, 99);
                d0   = 8'(int'(CHAR_ZERO) + $urandom_range(0, 9));
                if (sq_dir == DIR_ENCIPHER)
                begin
                    if (pick < 45)
                        it = byte_item(8'(int'(CHAR_UPPER_A) + $urandom_range(0, 25)), 1'b0);
                    else if (pick < 85)
                        it = byte_item(8'(int'(CHAR_LOWER_A) + $urandom_range(0, 25)), 1'b0);
                    else if (pick < 96)
                        it = byte_item(8'($urandom_range(0, 255)), 1'b0);
                    else
                        it = byte_item(8'($urandom_range(0, 255)), 1'b1);
                    run_q.push_back(it);
                end
                else if (pick < 55)
                begin
                    // digit pair drawn from the current labels, well-formed unless a label lies outside 1..5
                    run_q.push_back(byte_item(CHAR_ZERO + 8'(sq_label[$urandom_range(0, 4)]),
                                              1'b0));
                    run_q.push_back(byte_item(CHAR_ZERO + 8'(sq_label[$urandom_range(0, 4)]),
                                              1'b0));
                end
                else if (pick < 65)
                begin
                    run_q.push_back(byte_item(d0, 1'b0));
                    run_q.push_back(byte_item(8'(int'(CHAR_ZERO) + $urandom_range(0, 9)), 1'b0));
                end
                else if (pick < 78)
                begin
                    run_q.push_back(byte_item(8'($urandom_range(0, 255)), 1'b0));
                end
                else if (pick < 86)
                begin
                    run_q.push_back(byte_item($urandom_range(0, 1) ?
                                              8'(int'(CHAR_LOWER_A) + $urandom_range(0, 25)) :
                                              8'(int'(CHAR_UPPER_A) + $urandom_range(0, 25)),
                                              1'b0));
                end
                else if (pick < 93)
                begin
                    run_q.push_back(byte_item(d0, 1'b0));
                    run_q.push_back(byte_item(8'($urandom_range(0, 255)), 1'b0));
                end
                else if (pick < 97)
                begin
                    run_q.push_back(byte_item(d0, 1'b0));
                    run_q.push_back(byte_item(8'($urandom_range(0, 255)), 1'b1));
                end
                else
                begin
                    run_q.push_back(byte_item(8'($urandom_range(0, 255)), 1'b1));
                end
                foreach (run_q[i])
                begin
                    offer_item(run_q[i], -1, '0, '0);
                    if (!run_q[i].end_marker)
                    begin
                        count++;
                    end
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("covered %0d items in both directions over %0d square settings", items_sent,
                 NUM_PHASES + 4);
        $display("%0d results checked, %0d long receiver holds, %0d errors", results_checked,
                 long_holds, errors);
        if (errors == 0 && expected_codes.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
